/* rtl/core/mfbf_pkg.sv */
// ----------------------------------------------------------------------------
// mfbf_pkg
// Shared sizes, codes and the queue entry type of the framebuffer flush core.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbf_pkg;

   // Panel geometry and derived store sizes
   localparam int PanelWidth     = 128;
   localparam int PanelHeight    = 64;
   localparam int NumPages       = (PanelHeight + 7) / 8;
   localparam int StoreBytes     = PanelWidth * NumPages;
   localparam int StoreAddrWidth = $clog2(StoreBytes);
   localparam int CmdBytes       = 6;
   localparam int SeqLength      = CmdBytes + StoreBytes;
   localparam int PosWidth       = $clog2(SeqLength);
   localparam int QueueDepth     = 4;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);

   // Input item kinds
   localparam logic [1:0] KindPixel = 2'd0;
   localparam logic [1:0] KindFlush = 2'd1;
   localparam logic [1:0] KindTick  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CsrColumnCmd = 2'd0;
   localparam logic [1:0] CsrPageCmd   = 2'd1;

   // Reset values of the configuration registers
   localparam logic [7:0] ColumnCmdReset = 8'd33;
   localparam logic [7:0] PageCmdReset   = 8'd34;

   // Back-end operation codes
   typedef logic [1:0] op_type;
   localparam op_type OpPixel   = 2'd0;
   localparam op_type OpCommand = 2'd1;
   localparam op_type OpData    = 2'd2;

   // One unit of work handed from the front to the back
   typedef struct packed {
      op_type                    op;
      logic [StoreAddrWidth-1:0] addr;
      logic [2:0]                bit_sel;
      logic                      pixel_on;
      logic [7:0]                cmd_byte;
      logic                      last;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/core/mfbf_ram.sv */
// ----------------------------------------------------------------------------
// mfbf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbf_ram #(
   parameter int Width     = 8,
   parameter int Depth     = 1024,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [Width-1:0]     wr_data,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/mfbf_front.sv */
// ----------------------------------------------------------------------------
// mfbf_front
// Accepts input items, holds the command registers and the flush sequencer,
// and turns each item into at most one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic signed [8:0] req_pixel_x,
   input  wire logic signed [7:0] req_pixel_y,
   input  wire logic              req_pixel_on,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data,
   input  wire logic              store_ready,
   input  wire logic              queue_full,
   output logic                   push,
   output mfbf_pkg::entry_type    push_entry
);
   import mfbf_pkg::*;

   logic [7:0]          column_cmd_ff;
   logic [7:0]          page_cmd_ff;
   logic                flushing_ff;
   logic                flushing_in;
   logic [PosWidth-1:0] pos_ff;
   logic [PosWidth-1:0] pos_in;

   logic                accept;
   logic                x_ok;
   logic                y_ok;
   logic [31:0]         pix_addr_wide;
   logic [PosWidth-1:0] data_pos;
   logic                seq_last;
   logic [7:0]          cmd_byte;

   assign csr_ready = 1'b1;
   assign req_ready = store_ready && !queue_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_cmd_ff <= ColumnCmdReset;
         page_cmd_ff   <= PageCmdReset;
      end else if (csr_valid) begin
         if (csr_index == CsrColumnCmd) begin
            column_cmd_ff <= csr_data;
         end
         if (csr_index == CsrPageCmd) begin
            page_cmd_ff <= csr_data;
         end
      end
   end

   // Pixel range check and page-layout address
   assign x_ok = !req_pixel_x[8] && ({1'b0, req_pixel_x[7:0]} < 9'(PanelWidth));
   assign y_ok = !req_pixel_y[7] && ({1'b0, req_pixel_y[6:0]} < 8'(PanelHeight));
   assign pix_addr_wide = 32'(PanelWidth) * 32'(req_pixel_y[6:3]) + 32'(req_pixel_x[7:0]);

   assign data_pos = pos_ff - PosWidth'(CmdBytes);
   assign seq_last = (pos_ff == PosWidth'(SeqLength - 1));

   always_comb begin
      unique case (pos_ff)
         PosWidth'(0): cmd_byte = column_cmd_ff;
         PosWidth'(1): cmd_byte = 8'd0;
         PosWidth'(2): cmd_byte = 8'(PanelWidth - 1);
         PosWidth'(3): cmd_byte = page_cmd_ff;
         PosWidth'(4): cmd_byte = 8'd0;
         default:      cmd_byte = 8'd7;
      endcase
   end

   always_comb begin
      push                = 1'b0;
      flushing_in         = flushing_ff;
      pos_in              = pos_ff;
      push_entry.op       = OpPixel;
      push_entry.addr     = pix_addr_wide[StoreAddrWidth-1:0];
      push_entry.bit_sel  = req_pixel_y[2:0];
      push_entry.pixel_on = req_pixel_on;
      push_entry.cmd_byte = cmd_byte;
      push_entry.last     = seq_last;
      if (accept) begin
         case (req_kind)
            KindPixel: begin
               push = x_ok && y_ok;
            end
            KindFlush: begin
               flushing_in = 1'b1;
               pos_in      = '0;
            end
            KindTick: begin
               if (flushing_ff) begin
                  push = 1'b1;
                  if (pos_ff < PosWidth'(CmdBytes)) begin
                     push_entry.op = OpCommand;
                  end else begin
                     push_entry.op   = OpData;
                     push_entry.addr = data_pos[StoreAddrWidth-1:0];
                  end
                  // advance, or end the flush on its final byte
                  if (seq_last) begin
                     flushing_in = 1'b0;
                     pos_in      = '0;
                  end else begin
                     pos_in = pos_ff + PosWidth'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flushing_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         flushing_ff <= flushing_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mfbf_queue.sv */
// ----------------------------------------------------------------------------
// mfbf_queue
// Short register FIFO of work entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbf_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mfbf_pkg::entry_type push_entry,
   input  wire logic          pop,
   output mfbf_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import mfbf_pkg::*;

   entry_type                mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff;
   logic [QueuePtrWidth-1:0] rd_ptr_ff;
   logic [QueuePtrWidth:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QueuePtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrWidth'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QueuePtrWidth+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QueuePtrWidth+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mfbf_back.sv */
// ----------------------------------------------------------------------------
// mfbf_back
// Clears the frame store after reset, then executes queue entries: pixel
// read-modify-write, store byte read, command byte emit, into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbf_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mfbf_pkg::entry_type head,
   input  wire logic          q_empty,
   output logic               pop,
   output logic               store_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_is_data,
   output logic               rsp_last_byte
);
   import mfbf_pkg::*;

   localparam logic [1:0] StClear  = 2'd0;
   localparam logic [1:0] StIdle   = 2'd1;
   localparam logic [1:0] StModify = 2'd2;
   localparam logic [1:0] StRead   = 2'd3;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;
   logic [StoreAddrWidth-1:0] clr_ff;
   entry_type                 cur_ff;

   logic                      rsp_valid_ff;
   logic [7:0]                rsp_byte_ff;
   logic                      rsp_is_data_ff;
   logic                      rsp_last_ff;

   logic                      wr_en;
   logic [StoreAddrWidth-1:0] wr_addr;
   logic [7:0]                wr_data;
   logic [StoreAddrWidth-1:0] rd_addr;
   logic [7:0]                rd_data;
   logic [7:0]                mask;

   mfbf_ram #(
      .Width     (8),
      .Depth     (StoreBytes),
      .AddrWidth (StoreAddrWidth)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mask        = 8'b1 << cur_ff.bit_sel;
   assign store_ready = (state_ff != StClear);

   always_comb begin
      pop      = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cur_ff.addr;
      wr_data  = cur_ff.pixel_on ? (rd_data | mask) : (rd_data & ~mask);
      rd_addr  = head.addr;
      state_in = state_ff;
      unique case (state_ff)
         StClear: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'd0;
            if (clr_ff == StoreAddrWidth'(StoreBytes - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            // emitting entries wait for a free result register
            if (!q_empty && (head.op == OpPixel || !rsp_valid_ff)) begin
               pop = 1'b1;
               if (head.op == OpPixel) begin
                  state_in = StModify;
               end else if (head.op == OpData) begin
                  state_in = StRead;
               end
            end
         end
         StModify: begin
            wr_en    = 1'b1;
            state_in = StIdle;
         end
         StRead: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == StClear) begin
            clr_ff <= clr_ff + StoreAddrWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head.op == OpCommand) begin
         rsp_valid_ff <= 1'b1;
      end else if (state_ff == StRead) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.op == OpCommand) begin
         rsp_byte_ff    <= head.cmd_byte;
         rsp_is_data_ff <= 1'b0;
         rsp_last_ff    <= head.last;
      end else if (state_ff == StRead) begin
         rsp_byte_ff    <= rd_data;
         rsp_is_data_ff <= 1'b1;
         rsp_last_ff    <= cur_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_is_data   = rsp_is_data_ff;
   assign rsp_last_byte = rsp_last_ff;

   a_read_has_free_slot : assert property (@(posedge clock) disable iff (reset)
      state_ff == StRead |-> !rsp_valid_ff)
      else $error("store read finishing while result register is occupied");

   a_no_pop_in_clear : assert property (@(posedge clock) disable iff (reset)
      state_ff == StClear |-> !pop)
      else $error("queue popped during the clearing pass");

   a_data_pop_reads : assert property (@(posedge clock) disable iff (reset)
      pop && head.op == OpData |=> state_ff == StRead)
      else $error("data entry popped without a store read");

   a_modify_writes : assert property (@(posedge clock) disable iff (reset)
      pop && head.op == OpPixel |=> wr_en && !rsp_valid_ff == $past(!rsp_valid_ff)
         || wr_en && $past(rsp_valid_ff))
      else $error("pixel entry popped without a store write");

endmodule

`default_nettype wire

/* rtl/core/monochrome_framebuffer_flush_core.sv */
// ----------------------------------------------------------------------------
// monochrome_framebuffer_flush_core
// Path: a command byte passes the queue register and then the result register, a
//   store byte the queue register, the synchronous RAM read and the result register.
// Rate: flush starts make no queue entry, pixel writes do a RAM read-modify-write,
//   and command and store byte ticks wait until the result register drains.
// Reset: the frame store is cleared one byte a cycle, all StoreBytes (1024) bytes,
//   with req_ready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module monochrome_framebuffer_flush_core (
   input  wire logic              clock,
   input  wire logic              reset,
   // input item channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic signed [8:0] req_pixel_x,
   input  wire logic signed [7:0] req_pixel_y,
   input  wire logic              req_pixel_on,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_data,
   output logic                   rsp_last_byte,
   // configuration write channel
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data
);
   import mfbf_pkg::*;

   // front -> queue
   logic      push;
   entry_type push_entry;
   // queue -> back
   entry_type head;
   logic      q_empty;
   logic      q_full;
   logic      pop;
   // back -> front: clearing pass done
   logic      store_ready;

   // Front: classify each transfer, run the flush position counter and
   // drop items that leave no work (out-of-range pixels, idle ticks, kind 3).
   mfbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .req_pixel_on (req_pixel_on),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .store_ready  (store_ready),
      .queue_full   (q_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Queue: entries stay in transfer order, so a pixel write always lands
   // in the store before a later tick reads that byte.
   mfbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Back: own the frame store and the result register; hold a result
   // until its transfer while the front keeps filling the queue.
   mfbf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_empty       (q_empty),
      .pop           (pop),
      .store_ready   (store_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

/* verif/tb_monochrome_framebuffer_flush_core.sv */
// ----------------------------------------------------------------------------
// tb_monochrome_framebuffer_flush_core
// Self-checking bench for the page-layout frame store and its flush sequencer.
// A queue-fed driver sends pixel writes, flush starts and ticks. A predictor
// mirrors the store and the sequence position and holds the expected output
// bytes. A monitor checks every result transfer against the oldest expected
// byte. Random gaps on both channels, several register settings, and one
// complete flush down to the final byte.
// ----------------------------------------------------------------------------
module tb_monochrome_framebuffer_flush_core;
   import mfbf_pkg::*;

   // Codes the package leaves unnamed: the spare item kind and the spare
   // register indexes, all of which the block must ignore.
   localparam logic [1:0] KindSpare  = 2'd3;
   localparam logic [1:0] CsrSpareLo = 2'd2;
   localparam logic [1:0] CsrSpareHi = 2'd3;

   // Last command byte of the page range is fixed.
   localparam logic [7:0] PageRangeEnd = 8'd7;

   localparam int SettleCycles = 12;   // covers the path to the result register
   localparam int MaxReported  = 10;

   typedef struct {
      logic [1:0]        kind;
      logic signed [8:0] pixel_x;
      logic signed [7:0] pixel_y;
      logic              pixel_on;
   } panel_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last_byte;
   } flush_byte_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Block ports
   logic              req_valid    = 1'b0;
   logic              req_ready;
   logic [1:0]        req_kind     = KindPixel;
   logic signed [8:0] req_pixel_x  = '0;
   logic signed [7:0] req_pixel_y  = '0;
   logic              req_pixel_on = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready    = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_is_data;
   logic              rsp_last_byte;
   logic              csr_valid    = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index    = CsrColumnCmd;
   logic [7:0]        csr_data     = '0;

   monochrome_framebuffer_flush_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_pixel_on  (req_pixel_on),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_last_byte (rsp_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // Stimulus and expectation stores
   panel_item_type pending_items[$];
   flush_byte_type expected_bytes[$];

   // Gap rates, in percent, for the sender and the receiver
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;

   // Predicted block state
   logic [7:0]  column_cmd = ColumnCmdReset;
   logic [7:0]  page_cmd   = PageCmdReset;
   logic [7:0]  frame_image [StoreBytes];
   bit          flush_active = 1'b0;
   int unsigned flush_index  = 0;

   // Run statistics
   int unsigned mismatch_count    = 0;
   int unsigned pixels_applied    = 0;
   int unsigned pixels_dropped    = 0;
   int unsigned command_bytes_got = 0;
   int unsigned data_bytes_got    = 0;
   int unsigned flushes_finished  = 0;

   initial begin
      foreach (frame_image[i]) frame_image[i] = 8'h00;
   end

   function automatic void flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MaxReported) $display("MISMATCH: %s", what);
   endfunction

   // Update the mirrored store and sequencer for one accepted item and
   // append the byte it causes, if any.
   function automatic void predict_flush_output(panel_item_type it);
      flush_byte_type emitted;
      int          col;
      int          row;
      int unsigned addr;
      col = it.pixel_x;
      row = it.pixel_y;
      if (it.kind == KindPixel) begin
         // drop anything off the panel, negative coordinates included
         if (col >= 0 && col < PanelWidth && row >= 0 && row < PanelHeight) begin
            addr = col + (row / 8) * PanelWidth;
            frame_image[addr][row % 8] = it.pixel_on;
            pixels_applied++;
         end else begin
            pixels_dropped++;
         end
      end else if (it.kind == KindFlush) begin
         // a start in mid-flush rewinds to the first command byte
         flush_active = 1'b1;
         flush_index  = 0;
      end else if (it.kind == KindTick && flush_active) begin
         if (flush_index < CmdBytes) begin
            emitted.is_data = 1'b0;
            case (flush_index)
               0: emitted.out_byte = column_cmd;
               1: emitted.out_byte = 8'h00;
               2: emitted.out_byte = 8'(PanelWidth - 1);
               3: emitted.out_byte = page_cmd;
               4: emitted.out_byte = 8'h00;
               default: emitted.out_byte = PageRangeEnd;
            endcase
         end else begin
            emitted.is_data  = 1'b1;
            emitted.out_byte = frame_image[flush_index - CmdBytes];
         end
         emitted.last_byte = (flush_index + 1 == SeqLength);
         if (emitted.last_byte) begin
            flush_active = 1'b0;
            flush_index  = 0;
         end else begin
            flush_index++;
         end
         expected_bytes.push_back(emitted);
      end
      // idle ticks and the spare kind leave everything as it is
   endfunction

   // Driver: record the transfer that just happened, then present the next
   // pending item unless a gap is drawn. Valid and payload hold until taken.
   always @(posedge clock) begin : req_driver
      panel_item_type taken;
      panel_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken.kind     = req_kind;
            taken.pixel_x  = req_pixel_x;
            taken.pixel_y  = req_pixel_y;
            taken.pixel_on = req_pixel_on;
            predict_flush_output(taken);
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               next_item = pending_items.pop_front();
               req_valid    <= 1'b1;
               req_kind     <= next_item.kind;
               req_pixel_x  <= next_item.pixel_x;
               req_pixel_y  <= next_item.pixel_y;
               req_pixel_on <= next_item.pixel_on;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expected byte,
   // then draw the receiver's stall for the next cycle.
   always @(posedge clock) begin : rsp_monitor
      flush_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_is_data) data_bytes_got++;
            else command_bytes_got++;
            if (rsp_last_byte) flushes_finished++;
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("unexpected byte %02h data=%0b last=%0b",
                  rsp_out_byte, rsp_is_data, rsp_last_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_is_data !== want.is_data ||
                   rsp_last_byte !== want.last_byte) begin
                  flag_mismatch($sformatf(
                     "byte exp %02h data=%0b last=%0b, got %02h data=%0b last=%0b",
                     want.out_byte, want.is_data, want.last_byte,
                     rsp_out_byte, rsp_is_data, rsp_last_byte));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void queue_item(logic [1:0] kind, int col, int row, bit on);
      panel_item_type it;
      it.kind     = kind;
      it.pixel_x  = 9'(col);
      it.pixel_y  = 8'(row);
      it.pixel_on = on;
      pending_items.push_back(it);
   endfunction

   // Random pixel fields; for a pixel write, bias toward the first page so
   // that short flushes show the written bytes, with some off-panel values.
   function automatic void queue_random(logic [1:0] kind);
      int unsigned pick;
      pick = $urandom_range(99);
      if (kind == KindPixel && pick < 50) begin
         queue_item(kind, $urandom_range(31), $urandom_range(7), $urandom_range(1));
      end else if (kind == KindPixel && pick < 85) begin
         queue_item(kind, $urandom_range(PanelWidth - 1), $urandom_range(PanelHeight - 1),
            $urandom_range(1));
      end else begin
         queue_item(kind, $urandom_range(511), $urandom_range(255), $urandom_range(1));
      end
   endfunction

   // Mixed traffic: mostly ticks and pixel writes, occasional flush starts,
   // now and then a spare kind as noise.
   function automatic void queue_random_mix(int count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 60)      queue_random(KindTick);
         else if (pick < 93) queue_random(KindPixel);
         else if (pick < 96) queue_random(KindFlush);
         else                queue_random(KindSpare);
      end
   endfunction

   // One flush from start to its final byte, with pixel writes landing both
   // ahead of and behind the emitted position, then one idle tick.
   function automatic void queue_full_flush();
      queue_random(KindFlush);
      for (int i = 0; i < SeqLength; i++) begin
         if ($urandom_range(99) < 8) queue_random(KindPixel);
         queue_random(KindTick);
      end
      queue_random(KindTick);
   endfunction

   // Hold until every queued item is taken and every expected byte is in.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0);
   endtask

   // Drain, let the pipeline settle, then set the gap rates for a new phase.
   task automatic begin_phase(int unsigned gap_pct, int unsigned stall_pct);
      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CsrColumnCmd: column_cmd = value;
         CsrPageCmd:   page_cmd   = value;
         default: ;    // spare indexes change nothing
      endcase
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sparse sender gaps, heavy receiver stalls, reset values
      // of the command registers.
      @(negedge clock);
      req_gap_pct   = 7;
      rsp_stall_pct = 69;
      // corners of the panel, then set and clear of one bit
      queue_item(KindPixel, 0, 0, 1'b1);
      queue_item(KindPixel, PanelWidth - 1, PanelHeight - 1, 1'b1);
      queue_item(KindPixel, PanelWidth - 1, 0, 1'b1);
      queue_item(KindPixel, 0, PanelHeight - 1, 1'b1);
      queue_item(KindPixel, 5, 3, 1'b1);
      queue_item(KindPixel, 5, 3, 1'b0);
      // off-panel writes: just past each edge, negatives, field extremes
      queue_item(KindPixel, PanelWidth, 0, 1'b1);
      queue_item(KindPixel, 0, PanelHeight, 1'b1);
      queue_item(KindPixel, -1, 0, 1'b1);
      queue_item(KindPixel, 0, -1, 1'b1);
      queue_item(KindPixel, -256, -128, 1'b1);
      queue_item(KindPixel, 255, 127, 1'b1);
      // spare kind and a tick with no flush running: both silent
      queue_item(KindSpare, 0, 0, 1'b1);
      queue_item(KindTick, 255, -128, 1'b1);
      // the six command bytes
      queue_item(KindFlush, -256, 127, 1'b0);
      repeat (CmdBytes) queue_item(KindTick, 17, 9, 1'b1);
      // write ahead of the position, then read it back as the first data byte
      queue_item(KindPixel, 0, 1, 1'b1);
      queue_item(KindTick, 0, 0, 1'b0);
      // restart in mid-flush
      queue_item(KindFlush, 1, 1, 1'b1);
      queue_item(KindTick, 0, 0, 1'b0);

      // Pause the sender until all results are in, then continue at random.
      wait_for_drain();
      queue_random_mix(60);
      wait_for_drain();
      queue_random_mix(40);

      // Phase two: the other way round, extreme register values, and the
      // spare indexes which must not disturb them.
      begin_phase(69, 7);
      write_csr(CsrColumnCmd, 8'hFF);
      write_csr(CsrPageCmd, 8'h00);
      write_csr(CsrSpareLo, 8'h5A);
      write_csr(CsrSpareHi, 8'hA5);
      @(negedge clock);
      queue_full_flush();

      // Phase three: no gaps on either side, opposite extremes, then
      // random register values.
      begin_phase(0, 0);
      write_csr(CsrColumnCmd, 8'h00);
      write_csr(CsrPageCmd, 8'hFF);
      @(negedge clock);
      queue_random_mix(50);
      begin_phase(0, 0);
      write_csr(CsrColumnCmd, 8'($urandom_range(255)));
      write_csr(CsrPageCmd, 8'($urandom_range(255)));
      @(negedge clock);
      queue_random_mix(40);

      // Drain and let any stray output show up before closing.
      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);

      $display("Covered %0d pixel writes (%0d off panel), %0d command and %0d data bytes,",
         pixels_applied + pixels_dropped, pixels_dropped, command_bytes_got, data_bytes_got);
      $display("%0d complete flush(es), 3 gap profiles, 4 register settings.",
         flushes_finished);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
